// ===== design/gcpb_pkg.sv =====
// Shared types, constants and helper functions for the glyph coverage pixel blender.
package gcpb_pkg;

  localparam int unsigned PaletteEntries = 16;
  localparam int unsigned IdxW           = $clog2(PaletteEntries);
  localparam int unsigned ChanW          = 8;
  localparam int unsigned CovW           = 8;
  localparam int unsigned WordW          = 24;
  // Signed product of a channel difference and a coverage byte.
  localparam int unsigned ProdW          = ChanW + CovW + 1;

  localparam logic [CovW-1:0] CovNone = 8'h00;
  localparam logic [CovW-1:0] CovFull = 8'hff;

  typedef enum logic [1:0] {
    FMT_INDEXED = 2'd0,
    FMT_RGB555  = 2'd1,
    FMT_RGB565  = 2'd2,
    FMT_RGB888  = 2'd3
  } pix_fmt_t;

  localparam pix_fmt_t FmtReset = FMT_RGB565;

  typedef struct packed {
    logic [ChanW-1:0] r;
    logic [ChanW-1:0] g;
    logic [ChanW-1:0] b;
  } rgb_t;

  // Fixed 16-color palette.
  function automatic rgb_t pal_lookup(input logic [IdxW-1:0] idx);
    rgb_t c;
    case (idx)
      4'd0:    c = '{r: 8'h00, g: 8'h00, b: 8'h00};
      4'd1:    c = '{r: 8'haa, g: 8'h00, b: 8'h00};
      4'd2:    c = '{r: 8'h00, g: 8'haa, b: 8'h00};
      4'd3:    c = '{r: 8'haa, g: 8'h55, b: 8'h00};
      4'd4:    c = '{r: 8'h00, g: 8'h00, b: 8'haa};
      4'd5:    c = '{r: 8'haa, g: 8'h00, b: 8'haa};
      4'd6:    c = '{r: 8'h00, g: 8'haa, b: 8'haa};
      4'd7:    c = '{r: 8'haa, g: 8'haa, b: 8'haa};
      4'd8:    c = '{r: 8'h55, g: 8'h55, b: 8'h55};
      4'd9:    c = '{r: 8'hff, g: 8'h55, b: 8'h55};
      4'd10:   c = '{r: 8'h55, g: 8'hff, b: 8'h55};
      4'd11:   c = '{r: 8'hff, g: 8'hff, b: 8'h55};
      4'd12:   c = '{r: 8'h55, g: 8'h55, b: 8'hff};
      4'd13:   c = '{r: 8'hff, g: 8'h55, b: 8'hff};
      4'd14:   c = '{r: 8'h55, g: 8'hff, b: 8'hff};
      4'd15:   c = '{r: 8'hff, g: 8'hff, b: 8'hff};
      default: c = '{r: 8'h00, g: 8'h00, b: 8'h00};
    endcase
    return c;
  endfunction

  // Pack one color into a right-aligned framebuffer word (direct-color formats).
  function automatic logic [WordW-1:0] pack_rgb(input pix_fmt_t fmt, input rgb_t c);
    logic [WordW-1:0] w;
    case (fmt)
      FMT_RGB555: w = {9'd0, c.r[7:3], c.g[7:3], c.b[7:3]};
      FMT_RGB565: w = {8'd0, c.r[7:3], c.g[7:2], c.b[7:3]};
      default:    w = {c.r, c.g, c.b};
    endcase
    return w;
  endfunction

endpackage

// ===== design/glyph_coverage_pixel_blend.sv =====
// Top level of the glyph coverage pixel blender: three-stage blend and pack pipeline.
//
// Usage:
//   Input channel: drive in_coverage, in_fg_index, in_bg_index and in_span_end
//   with start high; the transfer happens at the rising edge where start is
//   high and busy is low. busy stays low, so one pixel can enter every clock.
//   Result channel: out_valid is high for exactly one cycle per pixel, with
//   out_pixel_word and out_span_end_out; the transfer ends with that cycle.
//   The receiver cannot stall the block, and none is needed: every pixel
//   leaves through the stage registers in turn, in input order.
//   Throughput is one pixel per clock; the stages are:
//     stage 1 - palette lookup of both indices, special-case flags
//     stage 2 - per-channel signed (fg - bg) * coverage multiply
//     stage 3 - add floor(product / 256) to bg, choose solid or blend, pack
//   Configuration: cfg_wr_en with cfg_wr_data writes pixel_format (0 indexed,
//   1 RGB555, 2 RGB565, 3 RGB888). Write it only while no pixel is in flight;
//   the format is sampled with each pixel at input transfer.
//   Reset (rst_n low, synchronous) clears all stage valid bits, drops any
//   pixel in flight and sets pixel_format to RGB565.
module glyph_coverage_pixel_blend (
  input  logic                               clk,
  input  logic                               rst_n,
  // input channel
  input  logic                               start,
  output logic                               busy,
  input  logic [gcpb_pkg::CovW-1:0]          in_coverage,
  input  logic [gcpb_pkg::IdxW-1:0]          in_fg_index,
  input  logic [gcpb_pkg::IdxW-1:0]          in_bg_index,
  input  logic                               in_span_end,
  // configuration
  input  logic                               cfg_wr_en,
  input  logic [1:0]                         cfg_wr_data,
  // result channel
  output logic                               out_valid,
  output logic [gcpb_pkg::WordW-1:0]         out_pixel_word,
  output logic                               out_span_end_out
);

  // Configuration register
  gcpb_pkg::pix_fmt_t fmt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= gcpb_pkg::FmtReset;
    end else if (cfg_wr_en) begin
      fmt_r <= gcpb_pkg::pix_fmt_t'(cfg_wr_data);
    end
  end

  // The pipeline never back-pressures.
  assign busy = 1'b0;

  logic in_xfer;
  assign in_xfer = start && !busy;

  // ---------------------------------------------------------------------------
  // Stage 1: palette lookup and special-case flags
  // ---------------------------------------------------------------------------
  logic                          v1_r;
  gcpb_pkg::rgb_t                fg1_r, bg1_r;
  logic [gcpb_pkg::CovW-1:0]     cov1_r;
  logic [gcpb_pkg::IdxW-1:0]     idx1_r;    // indexed-mode answer, picked by coverage bit 7
  logic                          solid_fg1_r, solid_bg1_r;
  gcpb_pkg::pix_fmt_t            fmt1_r;
  logic                          span1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_xfer;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      fg1_r       <= gcpb_pkg::pal_lookup(in_fg_index);
      bg1_r       <= gcpb_pkg::pal_lookup(in_bg_index);
      cov1_r      <= in_coverage;
      idx1_r      <= in_coverage[gcpb_pkg::CovW-1] ? in_fg_index : in_bg_index;
      solid_fg1_r <= (in_coverage == gcpb_pkg::CovFull);
      solid_bg1_r <= (in_coverage == gcpb_pkg::CovNone);
      fmt1_r      <= fmt_r;
      span1_r     <= in_span_end;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: signed channel difference times coverage
  // ---------------------------------------------------------------------------
  localparam int unsigned ProdW = gcpb_pkg::ProdW;

  function automatic logic signed [ProdW-1:0] chan_prod(
    input logic [gcpb_pkg::ChanW-1:0] fg,
    input logic [gcpb_pkg::ChanW-1:0] bg,
    input logic [gcpb_pkg::CovW-1:0]  cov
  );
    logic signed [gcpb_pkg::ChanW:0]   diff;
    logic signed [gcpb_pkg::CovW:0]    cov_s;
    logic signed [ProdW:0]             full;
    diff  = $signed({1'b0, fg}) - $signed({1'b0, bg});
    cov_s = $signed({1'b0, cov});
    full  = diff * cov_s;
    return full[ProdW-1:0];
  endfunction

  logic                          v2_r;
  logic signed [ProdW-1:0]       pr2_r, pg2_r, pb2_r;
  gcpb_pkg::rgb_t                fg2_r, bg2_r;
  logic [gcpb_pkg::IdxW-1:0]     idx2_r;
  logic                          solid_fg2_r, solid_bg2_r;
  gcpb_pkg::pix_fmt_t            fmt2_r;
  logic                          span2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (v1_r) begin
      pr2_r       <= chan_prod(fg1_r.r, bg1_r.r, cov1_r);
      pg2_r       <= chan_prod(fg1_r.g, bg1_r.g, cov1_r);
      pb2_r       <= chan_prod(fg1_r.b, bg1_r.b, cov1_r);
      fg2_r       <= fg1_r;
      bg2_r       <= bg1_r;
      idx2_r      <= idx1_r;
      solid_fg2_r <= solid_fg1_r;
      solid_bg2_r <= solid_bg1_r;
      fmt2_r      <= fmt1_r;
      span2_r     <= span1_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: finish the blend, pick solid or blended color, pack
  // ---------------------------------------------------------------------------
  // bits [15:8] of the product are floor(product / 256) modulo 256 for both
  // signs, which is all an 8-bit channel sum needs.
  gcpb_pkg::rgb_t            mix3;
  gcpb_pkg::rgb_t            col3;
  logic [gcpb_pkg::WordW-1:0] word_nxt;

  always_comb begin
    mix3.r = bg2_r.r + pr2_r[2*gcpb_pkg::ChanW-1:gcpb_pkg::ChanW];
    mix3.g = bg2_r.g + pg2_r[2*gcpb_pkg::ChanW-1:gcpb_pkg::ChanW];
    mix3.b = bg2_r.b + pb2_r[2*gcpb_pkg::ChanW-1:gcpb_pkg::ChanW];

    // Full coverage: use the exact foreground (the blend falls one step short where fg exceeds bg).
    if (solid_fg2_r) begin
      col3 = fg2_r;
    end else if (solid_bg2_r) begin
      col3 = bg2_r;
    end else begin
      col3 = mix3;
    end

    if (fmt2_r == gcpb_pkg::FMT_INDEXED) begin
      word_nxt = {{(gcpb_pkg::WordW-gcpb_pkg::IdxW){1'b0}}, idx2_r};
    end else begin
      word_nxt = gcpb_pkg::pack_rgb(fmt2_r, col3);
    end
  end

  logic                        out_valid_r;
  logic [gcpb_pkg::WordW-1:0]  out_word_r;
  logic                        out_span_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (v2_r) begin
      out_word_r <= word_nxt;
      out_span_r <= span2_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pixel_word   = out_word_r;
  assign out_span_end_out = out_span_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // Every input transfer comes out as a result strobe once it has passed through every pipeline register.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |-> ##3 out_valid)
    else $error("pixel did not emerge three clocks after input transfer");

  // No result strobe without a matching earlier input transfer.
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    !in_xfer |-> ##3 !out_valid)
    else $error("result strobe without input transfer");

  // Indexed mode only ever produces a palette index.
  a_indexed_narrow: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && fmt2_r == gcpb_pkg::FMT_INDEXED) |=>
      out_pixel_word[gcpb_pkg::WordW-1:gcpb_pkg::IdxW] == '0)
    else $error("indexed pixel word wider than a palette index");

  // 16-bit formats never set bits above bit 15.
  a_rgb16_narrow: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && (fmt2_r == gcpb_pkg::FMT_RGB555 || fmt2_r == gcpb_pkg::FMT_RGB565)) |=>
      out_pixel_word[gcpb_pkg::WordW-1:16] == '0)
    else $error("16-bit pixel word has upper bits set");

endmodule
